>>> src/qslp_pkg.sv
// Package for the quaternion slerp unit: CORDIC angle table, gain and fixed-point constants.
// It has no dependencies; the top level and the checker import it.
package qslp_pkg;

    localparam logic [31:0] GAIN_Q30 = 32'd652032874;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam int SMALL_SINE_SHIFT = 8;
    localparam int LAT_PER_BIT = 7;
    localparam int LAT_BASE = 34;

    function automatic logic [31:0] atan_q30(input int idx);
        logic [31:0] a;
        case (idx)
            0: a = 32'h3243F6A8;
            1: a = 32'h1DAC6705;
            2: a = 32'h0FADBAFC;
            3: a = 32'h07F56EA6;
            4: a = 32'h03FEAB76;
            5: a = 32'h01FFD55B;
            6: a = 32'h00FFFAAA;
            7: a = 32'h007FFF55;
            8: a = 32'h003FFFEA;
            9: a = 32'h001FFFFD;
            10: a = 32'h000FFFFF;
            11: a = 32'h0007FFFF;
            12: a = 32'h0003FFFF;
            13: a = 32'h0001FFFF;
            14: a = 32'h0000FFFF;
            15: a = 32'h00007FFF;
            16: a = 32'h00003FFF;
            17: a = 32'h00001FFF;
            18: a = 32'h00000FFF;
            19: a = 32'h000007FF;
            20: a = 32'h000003FF;
            21: a = 32'h000001FF;
            22: a = 32'h000000FF;
            23: a = 32'h0000007F;
            24: a = 32'h0000003F;
            25: a = 32'h0000001F;
            26: a = 32'h0000000F;
            27: a = 32'h00000008;
            28: a = 32'h00000004;
            29: a = 32'h00000002;
            30: a = 32'h00000001;
            default: a = 32'h0;
        endcase
        return a;
    endfunction

endpackage

>>> src/qslp_isqrt.sv
// Pipelined integer square root, one root bit per register stage.
// A side tag travels with each value. No package dependencies.
module qslp_isqrt #(
    parameter int IN_W = 31,
    parameter int ROOT_W = 16,
    parameter int TAG_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [IN_W-1:0]   in_value,
    input  logic [TAG_W-1:0]  in_tag,
    output logic              out_valid,
    output logic [ROOT_W-1:0] out_root,
    output logic [TAG_W-1:0]  out_tag
);

    localparam int CW = 2 * ROOT_W + 1;

    logic              valid_reg [ROOT_W];
    logic [IN_W-1:0]   rem_reg [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [TAG_W-1:0]  tag_reg [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        localparam int B = ROOT_W - 1 - k;
        logic              valid_i;
        logic [IN_W-1:0]   rem_i;
        logic [ROOT_W-1:0] root_i;
        logic [TAG_W-1:0]  tag_i;
        logic [CW-1:0]     cand;
        logic              take;
        logic [IN_W-1:0]   rem_next;
        logic [ROOT_W-1:0] root_next;

        if (k == 0) begin : g_first
            assign valid_i = in_valid;
            assign rem_i = in_value;
            assign root_i = '0;
            assign tag_i = in_tag;
        end
        else begin : g_later
            assign valid_i = valid_reg[k-1];
            assign rem_i = rem_reg[k-1];
            assign root_i = root_reg[k-1];
            assign tag_i = tag_reg[k-1];
        end

        assign cand = (CW'(root_i) << (B + 1)) + (CW'(1) << (2 * B));
        assign take = CW'(rem_i) >= cand;
        assign rem_next = take ? IN_W'(CW'(rem_i) - cand) : rem_i;
        assign root_next = take ? (root_i | (ROOT_W'(1) << B)) : root_i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_i;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= rem_next;
            root_reg[k] <= root_next;
            tag_reg[k] <= tag_i;
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign out_root = root_reg[ROOT_W-1];
    assign out_tag = tag_reg[ROOT_W-1];

endmodule

>>> src/qslp_div.sv
// Pipelined restoring divider, one quotient bit per register stage, several lanes
// sharing one divisor, with a side tag. No package dependencies.
module qslp_div #(
    parameter int N_W = 31,
    parameter int D_W = 16,
    parameter int LANES = 2,
    parameter int TAG_W = 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [LANES*N_W-1:0]   in_dividend,
    input  logic [D_W-1:0]         in_divisor,
    input  logic [TAG_W-1:0]       in_tag,
    output logic                   out_valid,
    output logic [LANES*N_W-1:0]   out_quotient,
    output logic [TAG_W-1:0]       out_tag
);

    logic             valid_reg [N_W];
    logic [N_W-1:0]   num_reg [N_W][LANES];
    logic [D_W-1:0]   rem_reg [N_W][LANES];
    logic [D_W-1:0]   dvs_reg [N_W];
    logic [TAG_W-1:0] tag_reg [N_W];

    for (genvar k = 0; k < N_W; k++) begin : g_stage
        logic             valid_i;
        logic [D_W-1:0]   dvs_i;
        logic [TAG_W-1:0] tag_i;

        if (k == 0) begin : g_first
            assign valid_i = in_valid;
            assign dvs_i = in_divisor;
            assign tag_i = in_tag;
        end
        else begin : g_later
            assign valid_i = valid_reg[k-1];
            assign dvs_i = dvs_reg[k-1];
            assign tag_i = tag_reg[k-1];
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [N_W-1:0] num_i;
            logic [D_W-1:0] rem_i;
            logic [D_W:0]   trial;
            logic           ge;

            if (k == 0) begin : g_first
                assign num_i = in_dividend[l*N_W +: N_W];
                assign rem_i = '0;
            end
            else begin : g_later
                assign num_i = num_reg[k-1][l];
                assign rem_i = rem_reg[k-1][l];
            end

            assign trial = {rem_i, num_i[N_W-1]};
            assign ge = trial >= {1'b0, dvs_i};

            always_ff @(posedge clk)
            begin
                rem_reg[k][l] <= ge ? D_W'(trial - {1'b0, dvs_i}) : D_W'(trial);
                num_reg[k][l] <= {num_i[N_W-2:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_i;
            end
        end

        always_ff @(posedge clk)
        begin
            dvs_reg[k] <= dvs_i;
            tag_reg[k] <= tag_i;
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_out
        assign out_quotient[l*N_W +: N_W] = num_reg[N_W-1][l];
    end

    assign out_valid = valid_reg[N_W-1];
    assign out_tag = tag_reg[N_W-1];

endmodule

>>> src/quaternion_slerp_unit.sv
// Top level of the quaternion slerp unit: dot product, CORDIC arc and sine, weights,
// blend and renormalization. Depends on qslp_pkg, qslp_isqrt and qslp_div.
//
// Usage: drive the two quaternions and the fraction and raise start for one cycle; a
// transfer happens at every rising edge where start is high and busy is low. busy is
// always low, so a new item may enter every cycle and throughput is one item per cycle.
// Each result appears on the blend ports together with linear_fallback and zero_norm
// for exactly one cycle, marked by done. The pipeline is built from the bit-per-stage
// square roots, the two CORDIC pipelines and the bit-per-stage dividers.
// Results leave in the order the items entered; the receiver cannot stall, so the
// pipeline never holds. Reset clears every valid bit, dropping all items in flight;
// done stays low until the first item after reset has passed through.
module quaternion_slerp_unit #(
    parameter int FRACTION_BITS = 15
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] first_w,
    input  logic signed [15:0] first_x,
    input  logic signed [15:0] first_y,
    input  logic signed [15:0] first_z,
    input  logic signed [15:0] second_w,
    input  logic signed [15:0] second_x,
    input  logic signed [15:0] second_y,
    input  logic signed [15:0] second_z,
    input  logic [16:0]        fraction,
    output logic               done,
    output logic signed [15:0] blend_w,
    output logic signed [15:0] blend_x,
    output logic signed [15:0] blend_y,
    output logic signed [15:0] blend_z,
    output logic               linear_fallback,
    output logic               zero_norm
);

    import qslp_pkg::*;

    localparam int F = FRACTION_BITS;
    localparam int SH = 30 - F;
    localparam int VW = F + 3;
    localparam int TH = F + 2;
    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};
    localparam logic [F:0] SMALL_SINE = ONE >> SMALL_SINE_SHIFT;
    localparam logic [31:0] GAIN_F = GAIN_Q30 >> SH;
    localparam int T1 = 128 + 17 + 1 + F + 1;
    localparam int TV = 128 + 17 + 1 + F + 1 + 1;
    localparam int TD1 = 128 + 17 + 1 + 1;
    localparam int DW1 = 2 * F + 1;
    localparam int TS2 = 4 * (F + 1) + 4 + 1;
    localparam int DW2 = F + 17;

    assign busy = 1'b0;

    // Stage 1: register inputs and form the four dot-product terms.
    logic signed [15:0] p_in [4];
    logic signed [15:0] q_in [4];
    logic               s1_valid_reg;
    logic [127:0]       s1_pq_reg;
    logic [16:0]        s1_u_reg;
    logic signed [31:0] s1_prod_reg [4];

    assign p_in[0] = first_w;
    assign p_in[1] = first_x;
    assign p_in[2] = first_y;
    assign p_in[3] = first_z;
    assign q_in[0] = second_w;
    assign q_in[1] = second_x;
    assign q_in[2] = second_y;
    assign q_in[3] = second_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_pq_reg <= {second_z, second_y, second_x, second_w,
                      first_z, first_y, first_x, first_w};
        s1_u_reg <= (fraction > 17'd65536) ? 17'd65536 : fraction;
        for (int i = 0; i < 4; i++)
        begin
            s1_prod_reg[i] <= p_in[i] * q_in[i];
        end
    end

    // Stage 2: dot product, its sign and the clamped cosine in Q(F).
    logic signed [33:0] dot_next;
    logic [33:0]        adot;
    logic [30:0]        aclip;
    logic [F:0]         s2_cq_next;
    logic               s2_valid_reg;
    logic [127:0]       s2_pq_reg;
    logic [16:0]        s2_u_reg;
    logic               s2_neg_reg;
    logic [F:0]         s2_cq_reg;

    always_comb
    begin
        dot_next = 34'(s1_prod_reg[0]) + 34'(s1_prod_reg[1])
                 + 34'(s1_prod_reg[2]) + 34'(s1_prod_reg[3]);
        adot = dot_next[33] ? 34'(-dot_next) : 34'(dot_next);
        aclip = (adot > 34'(ONE_Q30)) ? ONE_Q30 : adot[30:0];
        s2_cq_next = (F+1)'(aclip >> SH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_pq_reg <= s1_pq_reg;
        s2_u_reg <= s1_u_reg;
        s2_neg_reg <= dot_next[33];
        s2_cq_reg <= s2_cq_next;
    end

    // Stage 3: one minus cosine squared.
    logic [2*F+1:0] cq_sq;
    logic [2*F:0]   s3_rad_next;
    logic           s3_valid_reg;
    logic [T1-1:0]  s3_tag_reg;
    logic [2*F:0]   s3_rad_reg;

    assign cq_sq = (2*F+2)'(s2_cq_reg) * (2*F+2)'(s2_cq_reg);
    assign s3_rad_next = (2*F+1)'(((2*F+2)'(1) << (2 * F)) - cq_sq);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_tag_reg <= {s2_pq_reg, s2_u_reg, s2_neg_reg, s2_cq_reg};
        s3_rad_reg <= s3_rad_next;
    end

    // Sine of the arc.
    logic          r1_valid;
    logic [F:0]    r1_root;
    logic [T1-1:0] r1_tag;

    qslp_isqrt #(
        .IN_W(2 * F + 1),
        .ROOT_W(F + 1),
        .TAG_W(T1)
    ) u_sine_sqrt (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(s3_valid_reg),
        .in_value(s3_rad_reg),
        .in_tag(s3_tag_reg),
        .out_valid(r1_valid),
        .out_root(r1_root),
        .out_tag(r1_tag)
    );

    // Vectoring CORDIC: theta = atan2(s, c).
    logic                 vc_valid_reg [F+1];
    logic signed [VW-1:0] vc_x_reg [F+1];
    logic signed [VW-1:0] vc_y_reg [F+1];
    logic signed [VW-1:0] vc_z_reg [F+1];
    logic [TV-1:0]        vc_tag_reg [F+1];
    logic                 lin0;

    assign lin0 = r1_root < SMALL_SINE;

    for (genvar i = 0; i <= F; i++) begin : g_vec
        localparam logic [31:0] ANG_FULL = atan_q30(i) >> SH;
        localparam logic signed [VW-1:0] ANG = VW'(ANG_FULL);
        logic                 valid_i;
        logic signed [VW-1:0] xi;
        logic signed [VW-1:0] yi;
        logic signed [VW-1:0] zi;
        logic [TV-1:0]        ti;

        if (i == 0) begin : g_first
            assign valid_i = r1_valid;
            assign xi = $signed({2'b00, r1_tag[F:0]});
            assign yi = $signed({2'b00, r1_root});
            assign zi = '0;
            assign ti = {r1_tag[T1-1:F+1], r1_root, lin0};
        end
        else begin : g_later
            assign valid_i = vc_valid_reg[i-1];
            assign xi = vc_x_reg[i-1];
            assign yi = vc_y_reg[i-1];
            assign zi = vc_z_reg[i-1];
            assign ti = vc_tag_reg[i-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vc_valid_reg[i] <= 1'b0;
            end
            else
            begin
                vc_valid_reg[i] <= valid_i;
            end
        end

        always_ff @(posedge clk)
        begin
            if (yi > 0)
            begin
                vc_x_reg[i] <= xi + (yi >>> i);
                vc_y_reg[i] <= yi - (xi >>> i);
                vc_z_reg[i] <= zi + ANG;
            end
            else
            begin
                vc_x_reg[i] <= xi - (yi >>> i);
                vc_y_reg[i] <= yi + (xi >>> i);
                vc_z_reg[i] <= zi - ANG;
            end
            vc_tag_reg[i] <= ti;
        end
    end

    // Angle products (1-u)*theta and u*theta.
    logic [TH-1:0]   theta;
    logic [16:0]     vc_u;
    logic [F+18:0]   ang_prod1;
    logic [F+18:0]   ang_prod2;
    logic            am_valid_reg;
    logic [TH-1:0]   am_a_reg [2];
    logic [TV-1:0]   am_tag_reg;

    assign theta = vc_z_reg[F][VW-1] ? '0 : vc_z_reg[F][TH-1:0];
    assign vc_u = vc_tag_reg[F][F+19:F+3];
    assign ang_prod1 = (F+19)'(17'd65536 - vc_u) * (F+19)'(theta);
    assign ang_prod2 = (F+19)'(vc_u) * (F+19)'(theta);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            am_valid_reg <= 1'b0;
        end
        else
        begin
            am_valid_reg <= vc_valid_reg[F];
        end
    end

    always_ff @(posedge clk)
    begin
        am_a_reg[0] <= ang_prod1[TH+15:16];
        am_a_reg[1] <= ang_prod2[TH+15:16];
        am_tag_reg <= vc_tag_reg[F];
    end

    // Rotation CORDIC, two lanes: sin(a1) and sin(a2).
    logic                 rc_valid_reg [F+1];
    logic signed [VW-1:0] rc_x_reg [F+1][2];
    logic signed [VW-1:0] rc_y_reg [F+1][2];
    logic signed [VW-1:0] rc_z_reg [F+1][2];
    logic [TV-1:0]        rc_tag_reg [F+1];

    for (genvar i = 0; i <= F; i++) begin : g_rot
        localparam logic [31:0] ANG_FULL = atan_q30(i) >> SH;
        localparam logic signed [VW-1:0] ANG = VW'(ANG_FULL);
        logic          valid_i;
        logic [TV-1:0] ti;

        if (i == 0) begin : g_first
            assign valid_i = am_valid_reg;
            assign ti = am_tag_reg;
        end
        else begin : g_later
            assign valid_i = rc_valid_reg[i-1];
            assign ti = rc_tag_reg[i-1];
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic signed [VW-1:0] xi;
            logic signed [VW-1:0] yi;
            logic signed [VW-1:0] zi;

            if (i == 0) begin : g_first
                assign xi = VW'(GAIN_F);
                assign yi = '0;
                assign zi = $signed({1'b0, am_a_reg[l]});
            end
            else begin : g_later
                assign xi = rc_x_reg[i-1][l];
                assign yi = rc_y_reg[i-1][l];
                assign zi = rc_z_reg[i-1][l];
            end

            always_ff @(posedge clk)
            begin
                if (!zi[VW-1])
                begin
                    rc_x_reg[i][l] <= xi - (yi >>> i);
                    rc_y_reg[i][l] <= yi + (xi >>> i);
                    rc_z_reg[i][l] <= zi - ANG;
                end
                else
                begin
                    rc_x_reg[i][l] <= xi + (yi >>> i);
                    rc_y_reg[i][l] <= yi - (xi >>> i);
                    rc_z_reg[i][l] <= zi + ANG;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rc_valid_reg[i] <= 1'b0;
            end
            else
            begin
                rc_valid_reg[i] <= valid_i;
            end
        end

        always_ff @(posedge clk)
        begin
            rc_tag_reg[i] <= ti;
        end
    end

    // Weight division sin(a) * 2^F / s.
    logic [F:0]       sine [2];
    logic [2*DW1-1:0] wd_dividend;
    logic             wd_valid;
    logic [2*DW1-1:0] wd_quotient;
    logic [TD1-1:0]   wd_tag;

    for (genvar l = 0; l < 2; l++) begin : g_sine
        logic [VW-1:0] yu;
        assign yu = rc_y_reg[F][l];
        assign sine[l] = yu[VW-1] ? '0 : ((yu > VW'(ONE)) ? ONE : yu[F:0]);
        assign wd_dividend[l*DW1 +: DW1] = {sine[l], {F{1'b0}}};
    end

    qslp_div #(
        .N_W(DW1),
        .D_W(F + 1),
        .LANES(2),
        .TAG_W(TD1)
    ) u_weight_div (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(rc_valid_reg[F]),
        .in_dividend(wd_dividend),
        .in_divisor(rc_tag_reg[F][F+1:1]),
        .in_tag({rc_tag_reg[F][TV-1:F+2], rc_tag_reg[F][0]}),
        .out_valid(wd_valid),
        .out_quotient(wd_quotient),
        .out_tag(wd_tag)
    );

    // Weight select: clamp, linear fallback and sign of the first weight.
    logic [F:0]         wq [2];
    logic [16:0]        wd_u;
    logic [F+16:0]      ush;
    logic [F:0]         w2_lin;
    logic [F:0]         w1_mag;
    logic [F:0]         w2_mag;
    logic signed [F+1:0] w1_next;
    logic signed [F+1:0] w2_next;
    logic                ws_valid_reg;
    logic signed [F+1:0] ws_w1_reg;
    logic signed [F+1:0] ws_w2_reg;
    logic [127:0]        ws_pq_reg;
    logic                ws_lin_reg;

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            wq[l] = (wd_quotient[l*DW1 +: DW1] > DW1'(ONE)) ? ONE
                                                            : wd_quotient[l*DW1 +: F+1];
        end
        wd_u = wd_tag[18:2];
        ush = {wd_u, {F{1'b0}}};
        w2_lin = ush[F+16:16];
        w1_mag = wd_tag[0] ? (ONE - w2_lin) : wq[0];
        w2_mag = wd_tag[0] ? w2_lin : wq[1];
        w1_next = wd_tag[1] ? -$signed({1'b0, w1_mag}) : $signed({1'b0, w1_mag});
        w2_next = $signed({1'b0, w2_mag});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_valid_reg <= 1'b0;
        end
        else
        begin
            ws_valid_reg <= wd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        ws_w1_reg <= w1_next;
        ws_w2_reg <= w2_next;
        ws_pq_reg <= wd_tag[TD1-1:19];
        ws_lin_reg <= wd_tag[0];
    end

    // Blend products.
    logic                 bp_valid_reg;
    logic signed [F+17:0] bp_reg [8];
    logic                 bp_lin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bp_valid_reg <= 1'b0;
        end
        else
        begin
            bp_valid_reg <= ws_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            bp_reg[i] <= ws_w1_reg * $signed(ws_pq_reg[16*i +: 16]);
            bp_reg[4+i] <= ws_w2_reg * $signed(ws_pq_reg[64 + 16*i +: 16]);
        end
        bp_lin_reg <= ws_lin_reg;
    end

    // Blend sums cut to Q(F-1), split into magnitude and sign.
    logic signed [F+18:0] bsum [4];
    logic signed [F+2:0]  cval [4];
    logic                 bs_valid_reg;
    logic [F:0]           bs_mag_reg [4];
    logic [3:0]           bs_sign_reg;
    logic                 bs_lin_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            bsum[i] = (F+19)'(bp_reg[i]) + (F+19)'(bp_reg[4+i]);
            cval[i] = bsum[i][F+18:16];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bs_valid_reg <= 1'b0;
        end
        else
        begin
            bs_valid_reg <= bp_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            bs_mag_reg[i] <= cval[i][F+2] ? (F+1)'(-cval[i]) : (F+1)'(cval[i]);
            bs_sign_reg[i] <= cval[i][F+2];
        end
        bs_lin_reg <= bp_lin_reg;
    end

    // Squares of the blend components.
    logic           sq_valid_reg;
    logic [2*F+1:0] sq_reg [4];
    logic [F:0]     sq_mag_reg [4];
    logic [3:0]     sq_sign_reg;
    logic           sq_lin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg <= 1'b0;
        end
        else
        begin
            sq_valid_reg <= bs_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            sq_reg[i] <= (2*F+2)'(bs_mag_reg[i]) * (2*F+2)'(bs_mag_reg[i]);
            sq_mag_reg[i] <= bs_mag_reg[i];
        end
        sq_sign_reg <= bs_sign_reg;
        sq_lin_reg <= bs_lin_reg;
    end

    // Squared norm.
    logic [2*F+3:0] n2_next;
    logic           ns_valid_reg;
    logic [2*F+3:0] ns_n2_reg;
    logic [TS2-1:0] ns_tag_reg;

    assign n2_next = (2*F+4)'(sq_reg[0]) + (2*F+4)'(sq_reg[1])
                   + (2*F+4)'(sq_reg[2]) + (2*F+4)'(sq_reg[3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ns_valid_reg <= 1'b0;
        end
        else
        begin
            ns_valid_reg <= sq_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ns_n2_reg <= n2_next;
        ns_tag_reg <= {sq_mag_reg[3], sq_mag_reg[2], sq_mag_reg[1], sq_mag_reg[0],
                       sq_sign_reg, sq_lin_reg};
    end

    // Norm.
    logic           r2_valid;
    logic [F+1:0]   r2_root;
    logic [TS2-1:0] r2_tag;

    qslp_isqrt #(
        .IN_W(2 * F + 4),
        .ROOT_W(F + 2),
        .TAG_W(TS2)
    ) u_norm_sqrt (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(ns_valid_reg),
        .in_value(ns_n2_reg),
        .in_tag(ns_tag_reg),
        .out_valid(r2_valid),
        .out_root(r2_root),
        .out_tag(r2_tag)
    );

    // Rounded dividends for the normalization.
    logic             dv_valid_reg;
    logic [4*DW2-1:0] dv_dividend_reg;
    logic [F+1:0]     dv_norm_reg;
    logic [5:0]       dv_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg <= 1'b0;
        end
        else
        begin
            dv_valid_reg <= r2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            dv_dividend_reg[i*DW2 +: DW2] <=
                DW2'({r2_tag[5 + i*(F+1) +: F+1], 15'b0}) + DW2'(r2_root >> 1);
        end
        dv_norm_reg <= r2_root;
        dv_tag_reg <= {r2_tag[4:1], r2_tag[0], r2_root == '0};
    end

    logic             nd_valid;
    logic [4*DW2-1:0] nd_quotient;
    logic [5:0]       nd_tag;

    qslp_div #(
        .N_W(DW2),
        .D_W(F + 2),
        .LANES(4),
        .TAG_W(6)
    ) u_norm_div (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(dv_valid_reg),
        .in_dividend(dv_dividend_reg),
        .in_divisor(dv_norm_reg),
        .in_tag(dv_tag_reg),
        .out_valid(nd_valid),
        .out_quotient(nd_quotient),
        .out_tag(nd_tag)
    );

    // Saturation and output register.
    logic signed [15:0] out_next [4];
    logic               done_reg;
    logic signed [15:0] blend_reg [4];
    logic               lin_reg;
    logic               zero_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            logic [DW2-1:0] r;
            r = nd_quotient[i*DW2 +: DW2];
            if (nd_tag[0])
            begin
                out_next[i] = '0;
            end
            else if (nd_tag[2+i])
            begin
                out_next[i] = (r > DW2'(32768)) ? -16'sd32768 : -$signed(r[15:0]);
            end
            else
            begin
                out_next[i] = (r > DW2'(32767)) ? 16'sd32767 : $signed(r[15:0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= nd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            blend_reg[i] <= out_next[i];
        end
        lin_reg <= nd_tag[1];
        zero_reg <= nd_tag[0];
    end

    assign done = done_reg;
    assign blend_w = blend_reg[0];
    assign blend_x = blend_reg[1];
    assign blend_y = blend_reg[2];
    assign blend_z = blend_reg[3];
    assign linear_fallback = lin_reg;
    assign zero_norm = zero_reg;

endmodule

>>> src/qslp_checker.sv
// Port-level checker for the quaternion slerp unit, bound to the top level.
// Depends on qslp_pkg for the latency constants.
module qslp_checker #(
    parameter int FRACTION_BITS = 15
) (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic signed [15:0] blend_w,
    input logic signed [15:0] blend_x,
    input logic signed [15:0] blend_y,
    input logic signed [15:0] blend_z,
    input logic               zero_norm
);

    import qslp_pkg::*;

    localparam int LAT = LAT_PER_BIT * FRACTION_BITS + LAT_BASE;

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("transfer did not produce a result at the expected latency");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without a matching input transfer");

    a_zero_norm_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && zero_norm) |->
        (blend_w == 16'sd0 && blend_x == 16'sd0 && blend_y == 16'sd0 && blend_z == 16'sd0))
        else $error("zero norm reported with nonzero blend");

    a_norm_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !zero_norm) |->
        !(blend_w == 16'sd0 && blend_x == 16'sd0 && blend_y == 16'sd0 && blend_z == 16'sd0))
        else $error("nonzero norm gave an all-zero blend");

endmodule

bind quaternion_slerp_unit qslp_checker #(.FRACTION_BITS(FRACTION_BITS)) u_qslp_checker (.*);

>>> tb/tb_top.sv
// Self-checking testbench for quaternion_slerp_unit: directed and random quaternion pairs
// go through a start/busy transfer, and every done result is compared with a built-in predictor.
// Depends on the RTL in src/ (qslp_pkg and quaternion_slerp_unit).
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = 15;
    localparam int DRAIN_CYCLES = 7 * FB + 33 + 60;
    localparam longint CYCLE_LIMIT = 400000;
    localparam longint ARC_Q30 [0:15] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
        64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF};
    localparam longint GAIN = 652032874;

    typedef struct {
        logic signed [15:0] a [4];
        logic signed [15:0] b [4];
        logic [16:0]        frac;
    } pair_t;

    typedef struct {
        logic signed [15:0] q [4];
        logic               lin;
        logic               zn;
    } blend_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [15:0] first_w = '0, first_x = '0, first_y = '0, first_z = '0;
    logic signed [15:0] second_w = '0, second_x = '0, second_y = '0, second_z = '0;
    logic [16:0] fraction = '0;
    logic done;
    logic signed [15:0] blend_w, blend_x, blend_y, blend_z;
    logic linear_fallback, zero_norm;

    pair_t pending_pairs[$];
    blend_t expected_blends[$];
    int errors = 0;
    longint cycles = 0;
    bit taken = 1'b1;
    int burst_left = 0;
    int gap_left = 0;

    quaternion_slerp_unit i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .first_w(first_w), .first_x(first_x), .first_y(first_y), .first_z(first_z),
        .second_w(second_w), .second_x(second_x), .second_y(second_y), .second_z(second_z),
        .fraction(fraction), .done(done),
        .blend_w(blend_w), .blend_x(blend_x), .blend_y(blend_y), .blend_z(blend_z),
        .linear_fallback(linear_fallback), .zero_norm(zero_norm)
    );

    always #5 clk = ~clk;

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint cordic_arc(input longint x, input longint y);
        longint z, dx, dy;
        z = 0;
        for (int i = 0; i <= FB; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x += dx; y -= dy; z += ARC_Q30[i] >>> (30 - FB);
            end
            else
            begin
                x -= dx; y += dy; z -= ARC_Q30[i] >>> (30 - FB);
            end
        end
        return (z < 0) ? 0 : z;
    endfunction

    function automatic longint arc_weight(input longint ang, input longint s);
        longint x, y, z, dx, dy, w;
        x = GAIN >>> (30 - FB);
        y = 0;
        z = ang;
        for (int i = 0; i <= FB; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= ARC_Q30[i] >>> (30 - FB);
            end
            else
            begin
                x += dx; y -= dy; z += ARC_Q30[i] >>> (30 - FB);
            end
        end
        if (y < 0) y = 0;
        if (y > (64'sd1 << FB)) y = 64'sd1 << FB;
        w = (y << FB) / s;
        return (w > (64'sd1 << FB)) ? (64'sd1 << FB) : w;
    endfunction

    function automatic blend_t predict_blend(input pair_t p);
        blend_t r;
        longint one, dot, ad, cq, s, theta, w1, w2, u;
        longint c [4];
        longint unsigned n2, n, mag, quo;
        one = 64'sd1 << FB;
        dot = 0;
        for (int i = 0; i < 4; i++) dot += longint'(p.a[i]) * longint'(p.b[i]);
        u = (p.frac > 17'd65536) ? 65536 : longint'(p.frac);
        ad = (dot < 0) ? -dot : dot;
        if (ad > (64'sd1 << 30)) ad = 64'sd1 << 30;
        cq = ad >>> (30 - FB);
        s = longint'(int_sqrt(one * one - cq * cq));
        r.lin = (s < (one >>> 8));
        if (r.lin)
        begin
            w2 = (u << FB) >>> 16;
            w1 = one - w2;
        end
        else
        begin
            theta = cordic_arc(cq, s);
            w1 = arc_weight(((65536 - u) * theta) >>> 16, s);
            w2 = arc_weight((u * theta) >>> 16, s);
        end
        if (dot < 0) w1 = -w1;
        n2 = 0;
        for (int i = 0; i < 4; i++)
        begin
            c[i] = (w1 * longint'(p.a[i]) + w2 * longint'(p.b[i])) >>> 16;
            n2 += longint'(c[i] * c[i]);
        end
        n = int_sqrt(n2);
        r.zn = (n == 0);
        for (int i = 0; i < 4; i++)
        begin
            r.q[i] = '0;
            if (n != 0)
            begin
                mag = (c[i] < 0) ? -c[i] : c[i];
                quo = ((mag << 15) + (n >> 1)) / n;
                if (c[i] < 0)
                    r.q[i] = (quo > 32768) ? -16'sd32768 : 16'(-longint'(quo));
                else
                    r.q[i] = (quo > 32767) ? 16'sd32767 : 16'(longint'(quo));
            end
        end
        return r;
    endfunction

    function automatic logic signed [15:0] clip16(input int v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return 16'(v);
    endfunction

    function automatic logic [16:0] rand_fraction();
        case ($urandom_range(0, 9))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'($urandom_range(65537, 131071));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic pair_t unit_pair();
        pair_t p;
        real va [4];
        real vb [4];
        real na, nb;
        na = 0.0;
        nb = 0.0;
        for (int i = 0; i < 4; i++)
        begin
            va[i] = real'(int'($urandom_range(0, 65535)) - 32768);
            vb[i] = real'(int'($urandom_range(0, 65535)) - 32768);
            na += va[i] * va[i];
            nb += vb[i] * vb[i];
        end
        if (na < 1.0) na = 1.0;
        if (nb < 1.0) nb = 1.0;
        for (int i = 0; i < 4; i++)
        begin
            p.a[i] = clip16(int'(va[i] * 32767.0 / $sqrt(na)));
            p.b[i] = clip16(int'(vb[i] * 32767.0 / $sqrt(nb)));
        end
        // Close or opposite pairs push the arc toward the small-sine path.
        if ($urandom_range(0, 2) == 0)
        begin
            for (int i = 0; i < 4; i++)
                p.b[i] = clip16(int'(p.a[i]) + int'($urandom_range(0, 2 ** $urandom_range(0, 9)))
                         - int'($urandom_range(0, 2 ** $urandom_range(0, 9))));
            if ($urandom_range(0, 1))
                for (int i = 0; i < 4; i++) p.b[i] = clip16(-int'(p.b[i]));
        end
        p.frac = rand_fraction();
        return p;
    endfunction

    function automatic pair_t const_pair(input int a0, input int a1, input int b0, input int b1,
                                         input int f);
        pair_t p;
        p.a = '{clip16(a0), clip16(a1), 16'sd0, 16'sd0};
        p.b = '{clip16(b0), clip16(b1), 16'sd0, 16'sd0};
        p.frac = 17'(f);
        return p;
    endfunction

    initial
    begin
        pair_t p;
        pending_pairs.push_back(const_pair(32767, 0, 0, 32767, 32768));
        pending_pairs.push_back(const_pair(32767, 0, 0, 32767, 0));
        pending_pairs.push_back(const_pair(32767, 0, 0, 32767, 65536));
        pending_pairs.push_back(const_pair(32767, 0, 0, 32767, 131071));
        pending_pairs.push_back(const_pair(32767, 0, 32767, 0, 20000));
        pending_pairs.push_back(const_pair(32767, 0, -32768, 0, 20000));
        pending_pairs.push_back(const_pair(32767, 0, 32700, 2000, 40000));
        pending_pairs.push_back(const_pair(23170, 23170, -23170, 23170, 32768));
        pending_pairs.push_back(const_pair(-32768, -32768, -32768, -32768, 50000));
        pending_pairs.push_back(const_pair(-32768, 0, 32767, 0, 32768));
        pending_pairs.push_back(const_pair(0, 0, 0, 0, 30000));
        pending_pairs.push_back(const_pair(0, 0, 32767, 0, 0));
        pending_pairs.push_back(const_pair(32767, 0, 0, 0, 65536));
        pending_pairs.push_back(const_pair(32767, 0, -32767, 0, 32768));
        pending_pairs.push_back(const_pair(100, -50, 30, 70, 10000));
        pending_pairs.push_back(const_pair(1, 0, 0, 1, 32768));
        p.a = '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767};
        p.b = '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768};
        p.frac = 17'd131071;
        pending_pairs.push_back(p);
        p.b = '{16'sd16384, -16'sd16384, 16'sd16384, -16'sd16384};
        p.frac = 17'd1;
        pending_pairs.push_back(p);
        for (int k = 0; k < 1700; k++)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    p.a[i] = 16'($urandom);
                    p.b[i] = 16'($urandom);
                end
                p.frac = 17'($urandom);
            end
            else
                p = unit_pair();
            pending_pairs.push_back(p);
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (pending_pairs.size() == 0 && taken && expected_blends.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && expected_blends.size() == 0)
            $display("quaternion_slerp_unit regression: pass");
        else
            $display("quaternion_slerp_unit regression: fail");
        $finish;
    end

    always @(negedge clk)
    begin
        if (rst_n && taken && gap_left > 0)
        begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
        end
        else if (rst_n && taken && pending_pairs.size() != 0)
        begin
            pair_t p;
            p = pending_pairs.pop_front();
            first_w <= p.a[0]; first_x <= p.a[1]; first_y <= p.a[2]; first_z <= p.a[3];
            second_w <= p.b[0]; second_x <= p.b[1]; second_y <= p.b[2]; second_z <= p.b[3];
            fraction <= p.frac;
            start <= 1'b1;
            taken = 1'b0;
            if (burst_left > 0)
                burst_left <= burst_left - 1;
            else
            begin
                burst_left <= $urandom_range(0, 40);
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
        end
        else if (taken)
            start <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("quaternion_slerp_unit regression: fail");
            $finish;
        end
        if (rst_n && start && !busy && !taken)
        begin
            pair_t p;
            p.a = '{first_w, first_x, first_y, first_z};
            p.b = '{second_w, second_x, second_y, second_z};
            p.frac = fraction;
            expected_blends.push_back(predict_blend(p));
            taken = 1'b1;
        end
        if (rst_n && done)
        begin
            if (expected_blends.size() == 0)
            begin
                $error("result transfer with no expectation pending");
                errors++;
            end
            else
            begin
                blend_t e;
                e = expected_blends.pop_front();
                if (blend_w !== e.q[0])
                begin
                    $error("blend_w expected %0d actual %0d", e.q[0], blend_w); errors++;
                end
                if (blend_x !== e.q[1])
                begin
                    $error("blend_x expected %0d actual %0d", e.q[1], blend_x); errors++;
                end
                if (blend_y !== e.q[2])
                begin
                    $error("blend_y expected %0d actual %0d", e.q[2], blend_y); errors++;
                end
                if (blend_z !== e.q[3])
                begin
                    $error("blend_z expected %0d actual %0d", e.q[3], blend_z); errors++;
                end
                if (linear_fallback !== e.lin)
                begin
                    $error("linear_fallback expected %0b actual %0b", e.lin, linear_fallback);
                    errors++;
                end
                if (zero_norm !== e.zn)
                begin
                    $error("zero_norm expected %0b actual %0b", e.zn, zero_norm); errors++;
                end
            end
        end
    end
endmodule
